/* src/rswp_pkg.sv */
// Package with the shared constants, types and command structures of the rank sorter.
`timescale 1ns / 1ps
`default_nettype none
package rswp_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned KeyW  = 31;
  localparam int unsigned PayW  = 32;

  typedef logic [KeyW-1:0]        key_t;
  typedef logic signed [PayW-1:0] payload_t;
  typedef logic [IdxW-1:0]        idx_t;
  typedef logic [CntW-1:0]        cnt_t;

  typedef struct packed {
    logic load;
    logic emit;
    logic emit_last;
    idx_t emit_rank;
    cnt_t count;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

/* src/rswp_in_if.sv */
// Input channel interface carrying key, payload and the set-closing flag.
`timescale 1ns / 1ps
`default_nettype none
interface rswp_in_if;
  logic               valid;
  logic               ready;
  rswp_pkg::key_t     key;
  rswp_pkg::payload_t payload;
  logic               last_in;

  modport source (output valid, output key, output payload, output last_in, input ready);
  modport sink (input valid, input key, input payload, input last_in, output ready);
endinterface
`default_nettype wire

/* src/rswp_out_if.sv */
// Output channel interface carrying the sorted key, payload and final-result flag.
`timescale 1ns / 1ps
`default_nettype none
interface rswp_out_if;
  logic               valid;
  logic               ready;
  rswp_pkg::key_t     sorted_key;
  rswp_pkg::payload_t sorted_payload;
  logic               last_out;

  modport source (output valid, output sorted_key, output sorted_payload, output last_out,
                  input ready);
  modport sink (input valid, input sorted_key, input sorted_payload, input last_out,
                output ready);
endinterface
`default_nettype wire

/* src/rswp_ctrl.sv */
// Controller state machine that sequences loading and ranked emission.
`timescale 1ns / 1ps
`default_nettype none
module rswp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_last_i,
  output logic                   in_ready_o,
  input  wire rswp_pkg::status_t status_i,
  output rswp_pkg::cmd_t         cmd_o
);

  localparam logic StLoad = 1'b0;
  localparam logic StEmit = 1'b1;

  logic           state_q, state_d;
  rswp_pkg::cnt_t cnt_q, cnt_d;
  rswp_pkg::idx_t rank_q, rank_d;
  logic           not_full;
  logic           in_acc;
  logic           last_rank;

  assign not_full   = (cnt_q < rswp_pkg::CntW'(rswp_pkg::Depth));
  assign in_ready_o = (state_q == StLoad);
  assign in_acc     = in_valid_i && in_ready_o;
  assign last_rank  = ((rswp_pkg::CntW'(rank_q) + rswp_pkg::CntW'(1)) == cnt_q);

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    rank_d          = rank_q;
    cmd_o.load      = 1'b0;
    cmd_o.emit      = 1'b0;
    cmd_o.emit_last = last_rank;
    cmd_o.emit_rank = rank_q;
    cmd_o.count     = cnt_q;
    unique case (state_q)
      StLoad: begin
        if (in_acc) begin
          if (not_full) begin
            cmd_o.load = 1'b1;
            cnt_d      = cnt_q + rswp_pkg::CntW'(1);
          end
          if (in_last_i) begin
            state_d = StEmit;
            rank_d  = '0;
          end
        end
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (last_rank) begin
            state_d = StLoad;
            cnt_d   = '0;
          end else begin
            rank_d = rank_q + rswp_pkg::IdxW'(1);
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q   <= '0;
      rank_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rank_q  <= rank_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= rswp_pkg::CntW'(rswp_pkg::Depth))
    else $error("Loaded count exceeds the store depth.");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> (cnt_q != '0))
    else $error("Emission started on an empty set.");

  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.emit_last) |=> (state_q == StLoad && cnt_q == '0))
    else $error("Set did not close after its final result.");

endmodule
`default_nettype wire

/* src/rswp_dp.sv */
// Datapath with the key, payload and rank stores, parallel rank update and output register.
`timescale 1ns / 1ps
`default_nettype none
module rswp_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rswp_pkg::cmd_t     cmd_i,
  output rswp_pkg::status_t       status_o,
  input  wire rswp_pkg::key_t     key_i,
  input  wire rswp_pkg::payload_t payload_i,
  rswp_out_if.source              out_o
);

  rswp_pkg::key_t     key_q   [rswp_pkg::Depth];
  rswp_pkg::payload_t pay_q   [rswp_pkg::Depth];
  rswp_pkg::idx_t     rank_q  [rswp_pkg::Depth];
  logic [rswp_pkg::Depth-1:0] used;
  logic [rswp_pkg::Depth-1:0] lt;
  logic [rswp_pkg::Depth-1:0] match;
  rswp_pkg::cnt_t     smaller;
  rswp_pkg::key_t     sel_key;
  rswp_pkg::payload_t sel_pay;
  logic               out_valid_q;
  rswp_pkg::key_t     out_key_q;
  rswp_pkg::payload_t out_pay_q;
  logic               out_last_q;

  always_comb begin
    smaller = '0;
    sel_key = '0;
    sel_pay = '0;
    for (int i = 0; i < rswp_pkg::Depth; i++) begin
      used[i]  = (rswp_pkg::CntW'(i) < cmd_i.count);
      lt[i]    = used[i] && (key_q[i] < key_i);
      match[i] = used[i] && (rank_q[i] == cmd_i.emit_rank);
      smaller  = smaller + rswp_pkg::CntW'(lt[i]);
      sel_key  = sel_key | (match[i] ? key_q[i] : '0);
      sel_pay  = sel_pay | (match[i] ? pay_q[i] : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < rswp_pkg::Depth; i++) begin
      if (cmd_i.load) begin
        if (used[i] && !lt[i]) begin
          rank_q[i] <= rank_q[i] + rswp_pkg::IdxW'(1);
        end
        if (cmd_i.count[rswp_pkg::IdxW-1:0] == rswp_pkg::IdxW'(i)) begin
          key_q[i]  <= key_i;
          pay_q[i]  <= payload_i;
          rank_q[i] <= smaller[rswp_pkg::IdxW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_key_q  <= sel_key;
      out_pay_q  <= sel_pay;
      out_last_q <= cmd_i.emit_last;
    end
  end

  assign status_o.out_free    = !out_valid_q || out_o.ready;
  assign out_o.valid          = out_valid_q;
  assign out_o.sorted_key     = out_key_q;
  assign out_o.sorted_payload = out_pay_q;
  assign out_o.last_out       = out_last_q;

  a_rank_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> $onehot(match))
    else $error("Emitted rank does not match exactly one stored entry.");

  a_emit_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q)
    else $error("Emitted entry did not reach the output register.");

endmodule
`default_nettype wire

/* src/rank_sorter_with_payload_unit.sv */
// Top level of the rank sorter that orders key and payload pairs by key.
//
//  Channel  Dir  Fields                                 Handshake
//  in_i     in   key, payload, last_in                  valid/ready
//  out_o    out  sorted_key, sorted_payload, last_out   valid/ready
//
// A pair is taken while loading; its rank is set against all stored entries at once.
// The transaction with last_in starts emission, one result per cycle from the rank lookup while the
// output is not stalled, and input is held off during emission.
// Reset empties the set at once; the stores themselves are not cleared.
// A stalled output holds its result in the output register and pauses emission.
`timescale 1ns / 1ps
`default_nettype none
module rank_sorter_with_payload_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rswp_in_if.sink   in_i,
  rswp_out_if.source out_o
);

  rswp_pkg::cmd_t    cmd;
  rswp_pkg::status_t status;

  rswp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last_in),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rswp_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .key_i     (in_i.key),
    .payload_i (in_i.payload),
    .out_o     (out_o)
  );

endmodule
`default_nettype wire

/* verif/tb_rank_sorter_with_payload_unit.sv */
// Self-checking testbench for the rank sorter: directed table plus random key/payload sets.
`timescale 1ns / 1ps
module tb_rank_sorter_with_payload_unit;

  localparam int NumItems   = 380;
  localparam int CalmItems  = 60;
  localparam int CycleLimit = 200000;
  localparam int DirRows    = 25;

  typedef struct packed {
    rswp_pkg::key_t     key;
    rswp_pkg::payload_t payload;
    logic               last_out;
  } pair_t;

  typedef struct packed {
    rswp_pkg::key_t     key;
    rswp_pkg::payload_t payload;
    logic               last_in;
    logic               typed;
    rswp_pkg::key_t     x_key;
    rswp_pkg::payload_t x_payload;
    logic               x_last;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rswp_in_if  in_ch ();
  rswp_out_if out_ch ();

  rank_sorter_with_payload_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Singles after reset and at the field extremes carry their result in the table.
  stim_row_t dir_rows [DirRows] = '{
    '{31'h0,        32'h0,        1'b1, 1'b1, 31'h0,        32'h0,        1'b1},
    '{31'h7FFFFFFF, 32'h80000000, 1'b1, 1'b1, 31'h7FFFFFFF, 32'h80000000, 1'b1},
    '{31'h0,        32'h7FFFFFFF, 1'b1, 1'b1, 31'h0,        32'h7FFFFFFF, 1'b1},
    '{31'h7FFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, 31'h7FFFFFFF, 32'hFFFFFFFF, 1'b1},
    '{31'd5,        32'd1,        1'b0, 1'b0, '0, '0, 1'b0},
    '{31'd5,        32'd2,        1'b0, 1'b0, '0, '0, 1'b0},
    '{31'd3,        32'd3,        1'b0, 1'b0, '0, '0, 1'b0},
    '{31'd5,        32'd4,        1'b1, 1'b0, '0, '0, 1'b0},
    '{31'h7FFFFFFF, 32'h55555555, 1'b0, 1'b0, '0, '0, 1'b0},
    '{31'h0,        32'hAAAAAAAA, 1'b0, 1'b0, '0, '0, 1'b0},
    '{31'd100,      32'd10,       1'b0, 1'b0, '0, '0, 1'b0},
    '{31'd100,      32'd11,       1'b0, 1'b0, '0, '0, 1'b0},
    '{31'h7FFFFFFF, 32'h12345678, 1'b0, 1'b0, '0, '0, 1'b0},
    '{31'd1,        32'hFFFFFFF0, 1'b0, 1'b0, '0, '0, 1'b0},
    '{31'd50,       32'd14,       1'b0, 1'b0, '0, '0, 1'b0},
    '{31'd100,      32'd15,       1'b0, 1'b0, '0, '0, 1'b0},
    '{31'h0,        32'd16,       1'b0, 1'b0, '0, '0, 1'b0},
    '{31'h2FFFF,    32'd17,       1'b0, 1'b0, '0, '0, 1'b0},
    '{31'd3,        32'd18,       1'b0, 1'b0, '0, '0, 1'b0},
    '{31'd3,        32'd19,       1'b0, 1'b0, '0, '0, 1'b0},
    '{31'd3,        32'd20,       1'b0, 1'b0, '0, '0, 1'b0},
    '{31'h40000000, 32'd21,       1'b0, 1'b0, '0, '0, 1'b0},
    '{31'h7FFFFFFE, 32'd22,       1'b0, 1'b0, '0, '0, 1'b0},
    '{31'd9,        32'd23,       1'b0, 1'b0, '0, '0, 1'b0},
    '{31'h0,        32'h7EADBEEF, 1'b1, 1'b0, '0, '0, 1'b0}
  };

  rswp_pkg::key_t     held_key  [rswp_pkg::Depth];
  rswp_pkg::payload_t held_pay  [rswp_pkg::Depth];
  int unsigned        held_rank [rswp_pkg::Depth];
  int unsigned        held_count = 0;
  pair_t              set_out   [$];
  pair_t              expected_sorted [$];

  bit calm_tail  = 1'b0;
  int mismatches = 0;
  int cycle_count = 0;

  function automatic void rank_update(input rswp_pkg::key_t k, input rswp_pkg::payload_t p,
                                      input logic fin);
    int unsigned smaller;
    pair_t ordered [rswp_pkg::Depth];
    smaller = 0;
    set_out.delete();
    if (held_count < rswp_pkg::Depth) begin
      for (int i = 0; i < held_count; i++) begin
        if (held_key[i] < k) smaller++;
        else held_rank[i]++;
      end
      held_key[held_count]  = k;
      held_pay[held_count]  = p;
      held_rank[held_count] = smaller;
      held_count++;
    end
    if (fin) begin
      for (int i = 0; i < held_count; i++) begin
        ordered[held_rank[i]] = '{held_key[i], held_pay[i], held_rank[i] == held_count - 1};
      end
      for (int r = 0; r < held_count; r++) set_out.push_back(ordered[r]);
      held_count = 0;
    end
  endfunction

  task automatic send_pair(input stim_row_t row);
    int gap;
    gap = 0;
    if (!calm_tail && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.key     <= row.key;
    in_ch.payload <= row.payload;
    in_ch.last_in <= row.last_in;
    @(negedge clk_i);
    while (!in_ch.ready) @(negedge clk_i);
    @(posedge clk_i);
    rank_update(row.key, row.payload, row.last_in);
    if (row.typed) begin
      expected_sorted.push_back('{row.x_key, row.x_payload, row.x_last});
    end else begin
      foreach (set_out[i]) expected_sorted.push_back(set_out[i]);
    end
  endtask

  initial begin : ready_gen
    int hold;
    int quiet;
    hold = 0;
    quiet = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (calm_tail) begin
        out_ch.ready <= 1'b1;
      end else if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else if (quiet > 0) begin
        out_ch.ready <= 1'b1;
        quiet--;
      end else if ($urandom_range(0, 3) == 0) begin
        quiet = $urandom_range(20, 60);
        out_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        hold = $urandom_range(0, 14);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(negedge clk_i) begin : result_check
    pair_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_sorted.size() == 0) begin
        $error("unexpected result: sorted_key %0h sorted_payload %0d", out_ch.sorted_key,
               out_ch.sorted_payload);
        mismatches++;
      end else begin
        want = expected_sorted.pop_front();
        if (out_ch.sorted_key !== want.key) begin
          $error("sorted_key: expected %0h, got %0h", want.key, out_ch.sorted_key);
          mismatches++;
        end
        if (out_ch.sorted_payload !== want.payload) begin
          $error("sorted_payload: expected %0d, got %0d", want.payload, out_ch.sorted_payload);
          mismatches++;
        end
        if (out_ch.last_out !== want.last_out) begin
          $error("last_out: expected %0b, got %0b", want.last_out, out_ch.last_out);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t row;
    int sent;
    int set_len;
    int key_mode;
    rswp_pkg::key_t k;
    in_ch.valid   <= 1'b0;
    in_ch.key     <= '0;
    in_ch.payload <= '0;
    in_ch.last_in <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++) send_pair(dir_rows[i]);

    sent = DirRows;
    while (sent < NumItems) begin
      set_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 12);
      key_mode = $urandom_range(0, 2);
      for (int j = 0; j < set_len; j++) begin
        case (key_mode)
          0: k = rswp_pkg::key_t'($urandom);
          1: k = rswp_pkg::key_t'($urandom_range(0, 7));
          default: begin
            k = $urandom_range(0, 1) ? '1 : '0;
            k[0] = $urandom_range(0, 1);
          end
        endcase
        row = '0;
        row.key     = k;
        row.payload = rswp_pkg::payload_t'($urandom);
        row.last_in = (j == set_len - 1);
        send_pair(row);
        sent++;
        if (sent >= NumItems - CalmItems) calm_tail = 1'b1;
      end
    end
    in_ch.valid <= 1'b0;

    while (expected_sorted.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
src/rswp_pkg.sv
src/rswp_in_if.sv
src/rswp_out_if.sv
src/rswp_ctrl.sv
src/rswp_dp.sv
src/rank_sorter_with_payload_unit.sv
verif/tb_rank_sorter_with_payload_unit.sv
